### rtl/core/list_intersection_probe_engine_defines.svh
// assertion macros shared by the list intersection probe engine
`ifndef LIST_INTERSECTION_PROBE_ENGINE_DEFINES_SVH
`define LIST_INTERSECTION_PROBE_ENGINE_DEFINES_SVH

// implication checked at every clock edge outside reset
`define LIPE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition that must hold at every clock edge outside reset
`define LIPE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

`endif

### rtl/core/lipe_pkg.sv
// shared constants, codes and types of the list intersection probe engine
`timescale 1ns / 1ps
package lipe_pkg;

    localparam int LIST_DEPTH = 64;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int VALUE_W    = 32;
    localparam int MODE_W     = 2;

    localparam int Q_DEPTH    = 2;
    localparam int Q_IDX_W    = 1;
    localparam int Q_CNT_W    = 2;

    // input mode codes
    localparam logic [MODE_W-1:0] MODE_STORE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PROBE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // command codes carried through the queue
    typedef enum logic [1:0] {
        OP_STORE = 2'd0,
        OP_PROBE = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic signed [VALUE_W-1:0]  value;
    } t_cmd;

endpackage

### rtl/core/lipe_front.sv
// front end: accepts input beats, classifies the mode and drops unused codes
`timescale 1ns / 1ps
module lipe_front
    import lipe_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [MODE_W-1:0]          i_mode,
    input  logic signed [VALUE_W-1:0]  i_value,
    output logic                       o_push,
    output t_cmd                       o_cmd,
    input  logic                       i_full
);

    logic r_seen;
    logic n_seen;
    logic known;
    t_op  op;

    always_comb begin
        known = 1'b1;
        op    = OP_STORE;
        unique case (i_mode)
            MODE_STORE: op = OP_STORE;
            MODE_PROBE: op = OP_PROBE;
            MODE_CLEAR: op = OP_CLEAR;
            default:    known = 1'b0;
        endcase
    end

    assign o_ready     = !i_full;
    // unused mode is taken from the channel but never queued
    assign o_push      = i_valid && o_ready && known;
    assign o_cmd.op    = op;
    assign o_cmd.value = i_value;

    // tracks whether any beat was ever taken, for idle visibility
    assign n_seen = r_seen || (i_valid && o_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else begin
            r_seen <= n_seen;
        end
    end

endmodule

### rtl/core/lipe_queue.sv
// two-entry command queue between the front end and the scan engine
`timescale 1ns / 1ps
module lipe_queue
    import lipe_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cmd  i_cmd,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_cmd  o_cmd
);

    t_cmd               r_slot [Q_DEPTH];
    logic [Q_IDX_W-1:0] r_wp;
    logic [Q_IDX_W-1:0] r_rp;
    logic [Q_CNT_W-1:0] r_cnt;
    logic [Q_CNT_W-1:0] n_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

### rtl/core/lipe_scan.sv
// back end: list storage, sequential probe scan and the result register
`timescale 1ns / 1ps
`include "list_intersection_probe_engine_defines.svh"
module lipe_scan
    import lipe_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_empty,
    input  t_cmd                       i_cmd,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [VALUE_W-1:0]  o_match_value,
    output logic                       o_last_match
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [VALUE_W-1:0]        r_list [LIST_DEPTH];
    logic [VALUE_W-1:0]        r_rd_data;

    logic [1:0]                r_state;
    logic [1:0]                n_state;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic [CNT_W-1:0]          r_idx;
    logic [CNT_W-1:0]          n_idx;
    logic                      r_b_valid;
    logic                      n_b_valid;
    logic                      r_b_end;
    logic                      n_b_end;
    logic                      r_pend;
    logic                      n_pend;
    logic signed [VALUE_W-1:0] r_probe;
    logic signed [VALUE_W-1:0] n_probe;
    logic                      r_ov;
    logic                      n_ov;
    logic signed [VALUE_W-1:0] r_om;
    logic signed [VALUE_W-1:0] n_om;
    logic                      r_ol;
    logic                      n_ol;

    logic                      out_free;
    logic                      b_hit;
    logic                      stall;
    logic                      rd_en;
    logic                      wr_en;

    assign out_free = !r_ov || i_ready;
    assign b_hit    = r_b_valid && (r_rd_data == VALUE_W'(r_probe));
    // a second hit pushes the held one out, which needs the result slot
    assign stall    = b_hit && r_pend && !out_free;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_b_valid = r_b_valid;
        n_b_end   = r_b_end;
        n_pend    = r_pend;
        n_probe   = r_probe;
        n_ov      = r_ov && !i_ready;
        n_om      = r_om;
        n_ol      = r_ol;
        o_pop     = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.op)
                        OP_STORE: begin
                            if (r_count < CNT_W'(LIST_DEPTH)) begin
                                wr_en   = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_PROBE: begin
                            n_probe   = i_cmd.value;
                            n_idx     = '0;
                            n_b_valid = 1'b0;
                            n_pend    = 1'b0;
                            if (r_count != '0) begin
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (!stall) begin
                    if (b_hit) begin
                        n_pend = 1'b1;
                        if (r_pend) begin
                            n_ov = 1'b1;
                            n_om = r_probe;
                            n_ol = 1'b0;
                        end
                    end
                    rd_en     = (r_idx < r_count);
                    n_b_valid = rd_en;
                    n_b_end   = (r_idx == CNT_W'(r_count - 1'b1));
                    if (rd_en) begin
                        n_idx = r_idx + 1'b1;
                    end
                    if (r_b_valid && r_b_end) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!r_pend) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_ov    = 1'b1;
                    n_om    = r_probe;
                    n_ol    = 1'b1;
                    n_pend  = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_list[r_count[IDX_W-1:0]] <= i_cmd.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_list[r_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_probe <= n_probe;
        r_om    <= n_om;
        r_ol    <= n_ol;
        r_b_end <= n_b_end;
        r_idx   <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_b_valid <= 1'b0;
            r_pend    <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_b_valid <= n_b_valid;
            r_pend    <= n_pend;
            r_ov      <= n_ov;
        end
    end

    assign o_valid       = r_ov;
    assign o_match_value = r_om;
    assign o_last_match  = r_ol;

    `LIPE_ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(LIST_DEPTH), "list count overflow")
    `LIPE_ASSERT_IMP(a_idle_no_pend, r_state == ST_IDLE, !r_pend, "held hit left in idle")
    `LIPE_ASSERT_IMP(a_read_in_scan, r_b_valid, r_state == ST_SCAN, "read data outside scan")
    `LIPE_ASSERT_IMP(a_idx_bound, r_state == ST_SCAN, r_idx <= r_count, "scan index past list")
    `LIPE_ASSERT_IMP(a_pop_idle, o_pop, r_state == ST_IDLE, "command popped mid scan")

endmodule

### rtl/core/list_intersection_probe_engine.sv
// top level of the nested-loop list intersection probe engine
//
//   beat     direction  fields                         handshake
//   command  in         i_mode, i_value                i_valid / o_ready
//   result   out        o_match_value, o_last_match    o_valid / i_ready
//
// store and clear are handled in the scan engine in the cycle they are dequeued,
// as is a probe of an empty list; any other probe passes through the dequeue,
// one list entry read per cycle from a single memory read port while the scan
// is not stalled, the registered read data and the final result hand-off
// a two-entry queue lets commands be taken while a probe is still scanning
// reset is synchronous, active low, and empties the list; no clearing pass
// a stalled result register holds the scan when a further hit arrives, and
// the final hand-off waits for the result register to free up
`timescale 1ns / 1ps
module list_intersection_probe_engine
    import lipe_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [MODE_W-1:0]          i_mode,
    input  logic signed [VALUE_W-1:0]  i_value,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [VALUE_W-1:0]  o_match_value,
    output logic                       o_last_match
);

    logic push;
    t_cmd push_cmd;
    logic full;
    logic pop;
    logic empty;
    t_cmd head_cmd;

    lipe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_mode  (i_mode),
        .i_value (i_value),
        .o_push  (push),
        .o_cmd   (push_cmd),
        .i_full  (full)
    );

    lipe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    lipe_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_match_value (o_match_value),
        .o_last_match  (o_last_match)
    );

endmodule
